[hdl/modexp_pkg.sv]
// modexp_pkg: shared types and defaults for the modular exponentiation block
// no dependencies; imported by modular_exponentiation
`timescale 1ns / 1ps

package modexp_pkg;

    // default operand width in bits
    localparam int DEF_WIDTH = 32;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_SKIP = 6'b000100,
        S_SQR  = 6'b001000,
        S_MUL  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

endpackage

[hdl/modular_exponentiation.sv]
// modular_exponentiation: left-to-right square-and-multiply, depends on modexp_pkg
// zero modulus: result zero, no product; else base reduced mod n by one product first,
// exponent zero then gives 1 mod n; S_FIN waits until the output register is free. One
// item at a time, a beat taken only in S_IDLE; the bit-serial multiplier takes one bit per
// step, and each exponent bit from the top set bit down costs one or two products
// reset (i_rst_n low, synchronous): sequencer idle, no result pending, modulus set to 1
`timescale 1ns / 1ps

module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // modulus register write
    input  logic                                i_cfg_wr_en,
    input  logic [WIDTH-1:0]                    i_cfg_wr_data,
    // input beats
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((2 * WIDTH + 7) / 8) * 8-1:0] i_s_tdata,   // base, exponent, zero fill
    // result beats
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [((WIDTH + 7) / 8) * 8-1:0]    o_m_tdata    // result, zero fill
);

    localparam int OUT_BYTES = (WIDTH + 7) / 8;
    localparam int KW        = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int EW        = $clog2(WIDTH + 1);

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_n;                  // modulus
    logic [WIDTH-1:0] r_b, n_b;             // base reduced mod n
    logic [WIDTH-1:0] r_r, n_r;             // running power
    logic [WIDTH-1:0] r_exp, n_exp;         // exponent, shifted left one bit per step
    logic [EW-1:0]    r_ecnt, n_ecnt;       // exponent bits not yet consumed
    logic             r_bit, n_bit;         // exponent bit of the current step
    logic [WIDTH-1:0] r_acc, n_acc;         // multiplier accumulator
    logic [WIDTH-1:0] r_a, n_a;             // multiplicand, added when the serial bit is one
    logic [WIDTH-1:0] r_mb, n_mb;           // multiplier, consumed msb first
    logic [KW-1:0]    r_k, n_k;             // multiplier bit counter
    logic [WIDTH-1:0] r_res, n_res;         // output register
    logic             r_ovalid, n_ovalid;

    // ---------------------------------------------------------------------
    // one step of the add-and-double multiplier:
    // acc' = (2 * acc + bit * a) mod n, with acc, a < n so the sum stays below 3n;
    // both corrections are formed side by side and the right one picked
    // ---------------------------------------------------------------------
    logic [WIDTH+2:0] w_sum, w_t1, w_t2;
    logic [WIDTH-1:0] w_step;
    logic [WIDTH-1:0] w_one;                // 1 mod n
    logic             w_mdone;
    logic             w_mul_busy;           // a product is in progress

    always_comb begin
        w_sum = {2'b00, r_acc, 1'b0} + (r_mb[WIDTH-1] ? {3'b000, r_a} : '0);
        w_t1  = w_sum - {3'b000, r_n};
        w_t2  = w_sum - {2'b00, r_n, 1'b0};
        if (!w_t2[WIDTH+2]) begin
            w_step = w_t2[WIDTH-1:0];
        end else if (!w_t1[WIDTH+2]) begin
            w_step = w_t1[WIDTH-1:0];
        end else begin
            w_step = w_sum[WIDTH-1:0];
        end
    end

    assign w_one      = (r_n == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign w_mdone    = (r_k == '0);
    assign w_mul_busy = r_state inside {S_RED, S_SQR, S_MUL};

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_b      = r_b;
        n_r      = r_r;
        n_exp    = r_exp;
        n_ecnt   = r_ecnt;
        n_bit    = r_bit;
        n_acc    = r_acc;
        n_a      = r_a;
        n_mb     = r_mb;
        n_k      = r_k;
        n_res    = r_res;
        n_ovalid = r_ovalid && !i_m_tready;

        // multiplier advances in every product state
        if (w_mul_busy) begin
            n_acc = w_step;
            n_mb  = {r_mb[WIDTH-2:0], 1'b0};
            n_k   = r_k - KW'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_exp  = i_s_tdata[2*WIDTH-1:WIDTH];
                    n_ecnt = EW'(WIDTH);
                    if (r_n == '0) begin
                        // modulus zero gives zero
                        n_r     = '0;
                        n_state = S_FIN;
                    end else begin
                        // base mod n as (1 mod n) * base
                        n_acc   = '0;
                        n_a     = w_one;
                        n_mb    = i_s_tdata[WIDTH-1:0];
                        n_k     = KW'(WIDTH - 1);
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (w_mdone) begin
                    n_b     = w_step;
                    n_r     = w_one;
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros of the exponent, one per cycle
                if (r_exp == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_exp  = {r_exp[WIDTH-2:0], 1'b0};
                    n_ecnt = r_ecnt - EW'(1);
                    if (r_exp[WIDTH-1]) begin
                        n_bit   = 1'b1;
                        n_acc   = '0;
                        n_a     = r_r;
                        n_mb    = r_r;
                        n_k     = KW'(WIDTH - 1);
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR, S_MUL: begin
                if (w_mdone) begin
                    n_r   = w_step;
                    n_acc = '0;
                    n_k   = KW'(WIDTH - 1);
                    if (r_state == S_SQR && r_bit) begin
                        n_a     = r_b;
                        n_mb    = w_step;
                        n_state = S_MUL;
                    end else if (r_ecnt == '0) begin
                        n_state = S_FIN;
                    end else begin
                        // next exponent bit: square again
                        n_a     = w_step;
                        n_mb    = w_step;
                        n_bit   = r_exp[WIDTH-1];
                        n_exp   = {r_exp[WIDTH-2:0], 1'b0};
                        n_ecnt  = r_ecnt - EW'(1);
                        n_state = S_SQR;
                    end
                end
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_ovalid || i_m_tready) begin
                    n_res    = r_r;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_n      <= WIDTH'(1);
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_n <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b    <= n_b;
        r_r    <= n_r;
        r_exp  <= n_exp;
        r_ecnt <= n_ecnt;
        r_bit  <= n_bit;
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_mb   <= n_mb;
        r_k    <= n_k;
        r_res  <= n_res;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = (OUT_BYTES * 8)'(r_res);

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_busy |-> (r_acc < r_n))
        else $error("multiplier accumulator not reduced");

    a_a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_busy |-> (r_a < r_n))
        else $error("multiplicand not reduced");

    a_base_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_b < r_n && r_mb < r_n || r_k != KW'(WIDTH - 1)))
        else $error("base or square not reduced at multiply start");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_ovalid || i_m_tready)) |=> (r_ovalid && r_res == $past(r_r)))
        else $error("result not loaded into output register");

endmodule
